// File: rtl/cws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cws_pkg;

	localparam int unsigned WordWidth = 32;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned BytesPerWord = WordWidth / ByteWidth;
	localparam logic [WordWidth-1:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [WordWidth-1:0] CrcInit = '0;

	typedef struct packed {
		logic [WordWidth-1:0] data_word;
		logic                 first_word;
		logic                 last_word;
	} cws_in_t;

	typedef struct packed {
		logic [WordWidth-1:0] crc_value;
		logic                 crc_final;
	} cws_out_t;

	// one byte, MSB first, unreflected
	function automatic logic [WordWidth-1:0] crc_byte(
		input logic [WordWidth-1:0] acc_in,
		input logic [ByteWidth-1:0] byte_in
	);
		logic [WordWidth-1:0] acc;
		acc = acc_in ^ {byte_in, {(WordWidth-ByteWidth){1'b0}}};
		for (int k = 0; k < ByteWidth; k++) begin
			if (acc[WordWidth-1]) begin
				acc = {acc[WordWidth-2:0], 1'b0} ^ CrcPoly;
			end else begin
				acc = {acc[WordWidth-2:0], 1'b0};
			end
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

// File: rtl/crc32_word_stream.sv
// Running CRC-32 (poly 04C11DB7, MSB first, init zero, no final xor) over
// a stream of 32-bit words, each word taken as four bytes, low byte first.
// Input channel: data_valid / data_stall / data. A beat carries one word,
// a first flag that restarts the CRC from zero and a last flag.
// Output channel: result_valid / result_stall / result. One beat per input
// beat: the CRC after that word, and the last flag echoed as crc_final.
// The last flag does not clear the CRC; only a first flag does.
// A word taken into the input register passes through the four-byte xor
// network into the result register. Throughput: one word per clock while
// the result is not stalled.
// Reset: both stages empty, CRC accumulator zero.
// Stall: a stalled result holds. The input register still takes one more
// word, after which data_stall follows result_stall in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module crc32_word_stream (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             data_valid,
	output logic                  data_stall,
	input  wire cws_pkg::cws_in_t data,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cws_pkg::cws_out_t     result
);

	logic                          valid_s1;
	cws_pkg::cws_in_t              item_s1;
	logic                          valid_s2;
	cws_pkg::cws_out_t             item_s2;
	logic [cws_pkg::WordWidth-1:0] acc_q;
	logic [cws_pkg::WordWidth-1:0] acc_next;
	logic                          adv_s2;
	logic                          move_s1;

	assign adv_s2     = !valid_s2 || !result_stall;
	assign move_s1    = valid_s1 && adv_s2;
	assign data_stall = valid_s1 && !adv_s2;

	cws_update u_update (
		.acc        (acc_q),
		.data_word  (item_s1.data_word),
		.first_word (item_s1.first_word),
		.acc_next   (acc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= cws_pkg::CrcInit;
		end else begin
			if (!data_stall) begin
				valid_s1 <= data_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s1) begin
				acc_q <= acc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!data_stall && data_valid) begin
			item_s1 <= data;
		end
		if (move_s1) begin
			item_s2.crc_value <= acc_next;
			item_s2.crc_final <= item_s1.last_word;
		end
	end

	assign result_valid = valid_s2;
	assign result       = item_s2;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled without a full pipe");

	a_move_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		move_s1 |=> valid_s2)
		else $error("word left stage 1 but no result appeared");

	a_acc_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> acc_q == item_s2.crc_value)
		else $error("accumulator and pending result disagree");

	a_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> $stable(acc_q))
		else $error("accumulator changed without a word");

endmodule

`default_nettype wire

// File: rtl/cws_update.sv
`timescale 1ns / 1ps
`default_nettype none

module cws_update (
	input  wire logic [cws_pkg::WordWidth-1:0] acc,
	input  wire logic [cws_pkg::WordWidth-1:0] data_word,
	input  wire logic                          first_word,
	output logic      [cws_pkg::WordWidth-1:0] acc_next
);

	logic [cws_pkg::WordWidth-1:0] seed;
	logic [cws_pkg::WordWidth-1:0] b0, b1, b2;

	// bytes absorbed low byte first
	assign seed     = first_word ? cws_pkg::CrcInit : acc;
	assign b0       = cws_pkg::crc_byte(seed, data_word[7:0]);
	assign b1       = cws_pkg::crc_byte(b0, data_word[15:8]);
	assign b2       = cws_pkg::crc_byte(b1, data_word[23:16]);
	assign acc_next = cws_pkg::crc_byte(b2, data_word[31:24]);

endmodule

`default_nettype wire

// File: tb/crc32_word_stream_test.sv
`timescale 1ns / 1ps

module crc32_word_stream_test;

	localparam int unsigned WordTarget = 2000;
	localparam int unsigned IdlePct = 17;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic data_valid = 1'b0;
	logic data_stall;
	cws_pkg::cws_in_t data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cws_pkg::cws_out_t result;

	cws_pkg::cws_in_t word_queue[$];
	cws_pkg::cws_out_t crc_due[$];
	logic [cws_pkg::WordWidth-1:0] crc_running = cws_pkg::CrcInit;
	cws_pkg::cws_out_t crc_next;
	cws_pkg::cws_out_t crc_want;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	logic steady;

	crc32_word_stream DUT (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data(data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// no idling on either side in this window
	assign steady = cycle_count >= 1000 && cycle_count < 1600;

	// bytes low first, each xored into the top byte, then eight shifts
	function automatic logic [cws_pkg::WordWidth-1:0] crc_after_word(
		input logic [cws_pkg::WordWidth-1:0] seed,
		input logic [cws_pkg::WordWidth-1:0] word
	);
		logic [cws_pkg::WordWidth-1:0] acc;
		logic carry;
		acc = seed;
		for (int b = 0; b < cws_pkg::BytesPerWord; b++) begin
			acc[cws_pkg::WordWidth-1 -: cws_pkg::ByteWidth] =
				acc[cws_pkg::WordWidth-1 -: cws_pkg::ByteWidth] ^
				word[b*cws_pkg::ByteWidth +: cws_pkg::ByteWidth];
			for (int s = 0; s < cws_pkg::ByteWidth; s++) begin
				carry = acc[cws_pkg::WordWidth-1];
				acc = acc << 1;
				if (carry) begin
					acc = acc ^ cws_pkg::CrcPoly;
				end
			end
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string what,
		input logic [cws_pkg::WordWidth-1:0] got,
		input logic [cws_pkg::WordWidth-1:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic queue_word(input logic [cws_pkg::WordWidth-1:0] w, input logic f,
		input logic l);
		cws_pkg::cws_in_t beat;
		beat.data_word = w;
		beat.first_word = f;
		beat.last_word = l;
		word_queue.push_back(beat);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
		end else begin
			if (data_valid && !data_stall) begin
				crc_running = crc_after_word(
					data.first_word ? cws_pkg::CrcInit : crc_running, data.data_word);
				crc_next.crc_value = crc_running;
				crc_next.crc_final = data.last_word;
				crc_due.push_back(crc_next);
			end
			if (!data_valid || !data_stall) begin
				if (word_queue.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
					data <= word_queue.pop_front();
					data_valid <= 1'b1;
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (crc_due.size() == 0) begin
					report_mismatch("beat with nothing expected", result.crc_value, '0);
				end else begin
					crc_want = crc_due.pop_front();
					if (result.crc_value !== crc_want.crc_value) begin
						report_mismatch("crc_value", result.crc_value, crc_want.crc_value);
					end
					if (result.crc_final !== crc_want.crc_final) begin
						report_mismatch("crc_final",
							{{(cws_pkg::WordWidth-1){1'b0}}, result.crc_final},
							{{(cws_pkg::WordWidth-1){1'b0}}, crc_want.crc_final});
					end
				end
			end
			result_stall <= !steady && $urandom_range(0, 99) < IdlePct;
		end
	end

	initial begin
		int unsigned msg_len;
		// no first flag straight after reset
		queue_word(32'h0000_0000, 1'b0, 1'b0);
		queue_word(32'hFFFF_FFFF, 1'b0, 1'b1);
		// keeps accumulating past a last word
		queue_word(32'h8000_0000, 1'b0, 1'b0);
		queue_word(32'h0000_0001, 1'b0, 1'b1);
		// first and last on one word
		queue_word(32'hFFFF_FFFF, 1'b1, 1'b1);
		queue_word(32'h0000_0000, 1'b1, 1'b1);
		queue_word(32'h8000_0000, 1'b1, 1'b1);
		queue_word(32'h0000_0001, 1'b1, 1'b1);
		// ordinary messages
		queue_word(32'h1234_5678, 1'b1, 1'b0);
		queue_word(32'hDEAD_BEEF, 1'b0, 1'b0);
		queue_word(32'h0000_00FF, 1'b0, 1'b1);
		queue_word(32'hFF00_0000, 1'b1, 1'b0);
		queue_word(32'hAAAA_AAAA, 1'b0, 1'b0);
		queue_word(32'h5555_5555, 1'b0, 1'b1);
		// restart in the middle of a message
		queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
		queue_word(32'h0000_0000, 1'b0, 1'b1);
		while (word_queue.size() < WordTarget) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_word($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				msg_len = $urandom_range(1, 8);
				for (int i = 0; i < msg_len; i++) begin
					queue_word($urandom, i == 0, i == msg_len - 1);
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (word_queue.size() != 0 || data_valid || crc_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
